>>> design/plps_pkg.sv
// Shared types and constants for the path lookahead point search unit.
// No dependencies.
`default_nettype none
package plps_pkg;

  localparam int CoordW = 32;
  localparam int DiffW  = 33;
  localparam int SqW    = 66;
  localparam int RegW   = 31;
  localparam int GoalIdxW = 10;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic {
    CFG_LOOKAHEAD = 1'b0,
    CFG_REACH     = 1'b1
  } cfg_idx_e;

  localparam logic [RegW-1:0] LookaheadRst = 31'd32768;
  localparam logic [RegW-1:0] ReachRst     = 31'd655360;

endpackage
`default_nettype wire

>>> design/plps_if.sv
// Valid/ready channel interfaces for input items and results.
// No dependencies.
`default_nettype none
interface plps_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic signed [31:0]  pos_x;
  logic signed [31:0]  pos_y;
  modport source (output valid, kind, pos_x, pos_y, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, output ready);
endinterface

interface plps_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  goal_x;
  logic signed [31:0]  goal_y;
  logic [9:0]          goal_index;
  logic                beyond_found;
  logic                was_clamped;
  logic                path_empty;
  modport source (output valid, goal_x, goal_y, goal_index, beyond_found, was_clamped,
                  path_empty, input ready);
  modport sink   (input valid, goal_x, goal_y, goal_index, beyond_found, was_clamped,
                  path_empty, output ready);
endinterface
`default_nettype wire

>>> design/path_lookahead_point_search_unit.sv
// Path lookahead point search: path store, scan sequencer and clamp sequencer.
// Depends on plps_pkg, plps_if, plps_mul, plps_sqrt, plps_div.
//
// Usage: in_if carries transactions of kind start (new path, first point),
// append (next point, dropped once PATH_DEPTH points are held) and pose query.
// Only a query yields a result on out_if; start, append and unused kinds
// give none. Configuration writes go through cfg_we_i/cfg_index_i/cfg_wdata_i;
// the user makes them only while the unit is idle (the unit does not enforce it).
// A query squares the lookahead and reach distances on the shared multiplier,
// then scans the stored points from the search index on, falling back to the
// last point; a clamped goal adds a square root and two divisions on the
// bit-serial root/divide units. in_if.ready is low while a query is in progress.
// An empty path answers with path_empty set.
// Reset clears the point count, the search index and the output valid, and
// loads the configuration defaults; the store needs no clearing pass.
// A result waits in an output register while out_if.ready is low; the unit
// takes further start/append transactions meanwhile, and a new query finishes
// its work and then holds until the register is free.
`default_nettype none
module path_lookahead_point_search_unit #(
  parameter int PATH_DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [plps_pkg::RegW-1:0]   cfg_wdata_i,
  plps_in_if.sink                     in_if,
  plps_out_if.source                  out_if
);
  import plps_pkg::*;

  localparam int IdxW = $clog2(PATH_DEPTH);
  localparam int CntW = $clog2(PATH_DEPTH + 1);

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001,
    S_LA   = 17'h00002,
    S_MR   = 17'h00004,
    S_PREP = 17'h00008,
    S_RD   = 17'h00010,
    S_MX   = 17'h00020,
    S_MY   = 17'h00040,
    S_CMP  = 17'h00080,
    S_CHK  = 17'h00100,
    S_SQRT = 17'h00200,
    S_NX   = 17'h00400,
    S_DX0  = 17'h00800,
    S_DX   = 17'h01000,
    S_NY   = 17'h02000,
    S_DY0  = 17'h04000,
    S_DY   = 17'h08000,
    S_DONE = 17'h10000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [RegW-1:0] la_q, reach_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_q    <= LookaheadRst;
      reach_q <= ReachRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LOOKAHEAD: la_q    <= cfg_wdata_i;
        CFG_REACH:     reach_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic in_acc;
  kind_e in_kind;
  assign in_if.ready = (state_q == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign in_kind     = kind_e'(in_if.kind);

  // path store
  logic [63:0]     mem [PATH_DEPTH];
  logic [63:0]     rdata_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [CntW-1:0] cnt_q, scan_q;
  logic [IdxW-1:0] sidx_q;

  assign mem_we = in_acc && ((in_kind == KIND_START) ||
                  ((in_kind == KIND_APPEND) && (cnt_q < CntW'(PATH_DEPTH))));
  assign mem_waddr = (in_kind == KIND_START) ? '0 : cnt_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= {in_if.pos_y, in_if.pos_x};
    rdata_q <= mem[scan_q[IdxW-1:0]];
  end

  // shared units
  logic [DiffW-1:0]  mul_a, mul_b;
  logic [SqW-1:0]    prod;
  logic              sq_start, sq_done;
  logic [DiffW-1:0]  sq_root;
  logic              dv_start, dv_done;
  logic [SqW-2:0]    dv_num, dv_quot;

  plps_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .p_o(prod));

  logic [SqW-1:0] d2_q;
  plps_sqrt u_sqrt (.clk_i, .rst_ni, .start_i(sq_start), .rad_i(d2_q),
                    .done_o(sq_done), .root_o(sq_root));

  logic [DiffW:0] dist_q;
  plps_div u_div (.clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num),
                  .den_i(dist_q), .done_o(dv_done), .quot_o(dv_quot));

  // datapath registers
  logic signed [CoordW-1:0] rx_q, ry_q, gx_q, gy_q;
  logic signed [DiffW-1:0]  dx_q, dy_q, dx_c, dy_c;
  logic [SqW-1:0]           sq_q, d2_c;
  logic [61:0]              la2_q, mr2_q;
  logic                     final_q, found_q, clamped_q, empty_q;

  logic signed [CoordW-1:0] px, py;
  assign px   = rdata_q[31:0];
  assign py   = rdata_q[63:32];
  assign dx_c = DiffW'(px) - DiffW'(rx_q);
  assign dy_c = DiffW'(py) - DiffW'(ry_q);
  assign d2_c = sq_q + prod;

  function automatic logic [DiffW-1:0] mag33(input logic signed [DiffW-1:0] v);
    mag33 = v[DiffW-1] ? DiffW'(-v) : DiffW'(v);
  endfunction

  function automatic logic signed [CoordW-1:0] sat_add(
    input logic signed [CoordW-1:0] base, input logic neg, input logic [SqW-2:0] q);
    logic signed [SqW:0] s;
    s = neg ? ((SqW+1)'(base) - $signed({2'b00, q}))
            : ((SqW+1)'(base) + $signed({2'b00, q}));
    if (s > $signed((SqW+1)'(32'sh7fffffff)))       sat_add = 32'sh7fffffff;
    else if (s < $signed((SqW+1)'(-33'sh80000000))) sat_add = 32'sh80000000;
    else                                            sat_add = s[CoordW-1:0];
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_LA:  begin mul_a = DiffW'(la_q);    mul_b = DiffW'(la_q);    end
      S_MR:  begin mul_a = DiffW'(reach_q); mul_b = DiffW'(reach_q); end
      S_MX:  begin mul_a = mag33(dx_c);     mul_b = mag33(dx_c);     end
      S_MY:  begin mul_a = mag33(dy_c);     mul_b = mag33(dy_c);     end
      S_NX:  begin mul_a = DiffW'(reach_q); mul_b = mag33(dx_q);     end
      S_NY:  begin mul_a = DiffW'(reach_q); mul_b = mag33(dy_q);     end
      default: ;
    endcase
  end

  assign sq_start = (state_q == S_CHK) && (d2_q > SqW'(mr2_q));
  assign dv_start = (state_q == S_DX0) || (state_q == S_DY0);
  assign dv_num   = (SqW-1)'(prod) + (SqW-1)'(dist_q >> 1);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc && (in_kind == KIND_QUERY)) begin
        state_d = (cnt_q == '0) ? S_DONE : S_LA;
      end
      S_LA:   state_d = S_MR;
      S_MR:   state_d = S_PREP;
      S_PREP: state_d = S_RD;
      S_RD:   state_d = S_MX;
      S_MX:   state_d = S_MY;
      S_MY:   state_d = S_CMP;
      S_CMP:  state_d = (final_q || (d2_c >= SqW'(la2_q))) ? S_CHK : S_RD;
      S_CHK:  state_d = sq_start ? S_SQRT : S_DONE;
      S_SQRT: if (sq_done) state_d = S_NX;
      S_NX:   state_d = S_DX0;
      S_DX0:  state_d = S_DX;
      S_DX:   if (dv_done) state_d = S_NY;
      S_NY:   state_d = S_DY0;
      S_DY0:  state_d = S_DY;
      S_DY:   if (dv_done) state_d = S_DONE;
      S_DONE: if (!out_if.valid || out_if.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      sidx_q  <= '0;
      scan_q  <= '0;
      final_q <= 1'b0;
      found_q <= 1'b0;
      clamped_q <= 1'b0;
      empty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        case (in_kind)
          KIND_START: begin
            cnt_q  <= CntW'(1);
            sidx_q <= '0;
          end
          KIND_APPEND: if (cnt_q < CntW'(PATH_DEPTH)) cnt_q <= cnt_q + 1'b1;
          KIND_QUERY: begin
            empty_q   <= (cnt_q == '0);
            found_q   <= 1'b0;
            clamped_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (state_q == S_PREP) begin
        if (CntW'(sidx_q) < cnt_q) begin
          scan_q  <= CntW'(sidx_q);
          final_q <= 1'b0;
        end else begin
          scan_q  <= cnt_q - 1'b1;
          final_q <= 1'b1;
        end
      end
      if ((state_q == S_CMP) && !final_q) begin
        if (d2_c >= SqW'(la2_q)) begin
          found_q <= 1'b1;
        end else if (scan_q + 1'b1 == cnt_q) begin
          final_q <= 1'b1;
        end else begin
          scan_q <= scan_q + 1'b1;
        end
      end
      if (state_q == S_CHK) begin
        sidx_q    <= scan_q[IdxW-1:0];
        clamped_q <= sq_start;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rx_q <= in_if.pos_x;
      ry_q <= in_if.pos_y;
    end
    if (state_q == S_MR)   la2_q <= prod[61:0];
    if (state_q == S_PREP) mr2_q <= prod[61:0];
    if (state_q == S_MX)   dx_q  <= dx_c;
    if (state_q == S_MY) begin
      dy_q <= dy_c;
      sq_q <= prod;
    end
    if (state_q == S_CMP)  d2_q <= d2_c;
    if (state_q == S_CHK) begin
      gx_q <= px;
      gy_q <= py;
    end
    if ((state_q == S_SQRT) && sq_done) begin
      dist_q <= (sq_root == '0) ? (DiffW+1)'(1) : (DiffW+1)'(sq_root);
    end
    if ((state_q == S_DX) && dv_done) gx_q <= sat_add(rx_q, dx_q[DiffW-1], dv_quot);
    if ((state_q == S_DY) && dv_done) gy_q <= sat_add(ry_q, dy_q[DiffW-1], dv_quot);
  end

  // output register
  logic out_load;
  assign out_load = (state_q == S_DONE) && (!out_if.valid || out_if.ready);

  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  logic signed [CoordW-1:0] ogx_q, ogy_q;
  logic [GoalIdxW-1:0]      oidx_q;
  logic                     ofound_q, oclamp_q, oempty_q;
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ogx_q    <= empty_q ? '0 : gx_q;
      ogy_q    <= empty_q ? '0 : gy_q;
      oidx_q   <= empty_q ? '0 : GoalIdxW'(sidx_q);
      ofound_q <= !empty_q && found_q;
      oclamp_q <= !empty_q && clamped_q;
      oempty_q <= empty_q;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.goal_x       = ogx_q;
  assign out_if.goal_y       = ogy_q;
  assign out_if.goal_index   = oidx_q;
  assign out_if.beyond_found = ofound_q;
  assign out_if.was_clamped  = oclamp_q;
  assign out_if.path_empty   = oempty_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(PATH_DEPTH)) else $error("point count past store depth");

  a_sidx_in_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) || (CntW'(sidx_q) < cnt_q)) else $error("search index outside path");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE)) else $error("result without done");

  a_clamp_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && oclamp_q |-> !oempty_q) else $error("clamped empty result");
`endif
endmodule
`default_nettype wire

>>> design/plps_mul.sv
// Shared registered 33x33 unsigned multiplier.
// Depends on plps_pkg.
`default_nettype none
module plps_mul (
  input  logic                      clk_i,
  input  logic [plps_pkg::DiffW-1:0] a_i,
  input  logic [plps_pkg::DiffW-1:0] b_i,
  output logic [plps_pkg::SqW-1:0]   p_o
);
  import plps_pkg::*;

  logic [SqW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= SqW'(a_i) * SqW'(b_i);
  end

  assign p_o = p_q;
endmodule
`default_nettype wire

>>> design/plps_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on plps_pkg.
`default_nettype none
module plps_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [plps_pkg::SqW-1:0]   rad_i,
  output logic                      done_o,
  output logic [plps_pkg::DiffW-1:0] root_o
);
  import plps_pkg::*;

  localparam int Steps = SqW / 2;
  localparam int CntW  = $clog2(Steps + 1);
  localparam int RemW  = DiffW + 4;

  logic [SqW-1:0]   rad_q;
  logic [RemW-1:0]  rem_q, rem_sh, trial;
  logic [DiffW-1:0] root_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;

  assign rem_sh = {rem_q[RemW-3:0], rad_q[SqW-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[DiffW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[DiffW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Steps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

>>> design/plps_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on plps_pkg.
`default_nettype none
module plps_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [plps_pkg::SqW-2:0]     num_i,
  input  logic [plps_pkg::DiffW:0]     den_i,
  output logic                        done_o,
  output logic [plps_pkg::SqW-2:0]     quot_o
);
  import plps_pkg::*;

  localparam int NumW = SqW - 1;
  localparam int DenW = DiffW + 1;
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, quot_q;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   rem_q, rem_sh;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;

  assign rem_sh = {rem_q[DenW-1:0], num_q[NumW-1]};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q  <= rem_sh - {1'b0, den_q};
        quot_q <= {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        quot_q <= {quot_q[NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule
`default_nettype wire

>>> sim/tb.sv
// Testbench for path_lookahead_point_search_unit: drives path points and pose queries,
// predicts each lookahead goal and checks it. Depends on plps_pkg, plps_if and the unit.
`timescale 1ns / 100ps
module tb;
  import plps_pkg::*;

  typedef struct {
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic [9:0]         idx;
    logic               found;
    logic               clamped;
    logic               empty;
  } goal_t;

  localparam int Depth = 1024;

  class goal_scoreboard;
    logic signed [31:0] pt_x[Depth];
    logic signed [31:0] pt_y[Depth];
    int unsigned        n_pts;
    int unsigned        scan_idx;
    bit [RegW-1:0]      la_dist;
    bit [RegW-1:0]      reach;
    goal_t              goals[$];
    int                 errors;

    function new();
      n_pts = 0;
      scan_idx = 0;
      la_dist = LookaheadRst;
      reach = ReachRst;
      errors = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function bit [65:0] sq_dist(longint dx, longint dy);
      bit [65:0] ax, ay;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      return ax * ax + ay * ay;
    endfunction

    function bit [32:0] root(bit [65:0] v);
      bit [32:0] r, c;
      bit [65:0] cc;
      r = 0;
      for (int b = 32; b >= 0; b--) begin
        c = r | (33'd1 << b);
        cc = c;
        if (cc * cc <= v) r = c;
      end
      return r;
    endfunction

    // round half away from zero, then saturate to the coordinate range
    function logic signed [31:0] pull_in(longint base, longint d, bit [32:0] dist_v);
      bit [65:0] m, rr, dd, qq;
      longint v;
      m = (d < 0) ? -d : d;
      rr = reach;
      dd = dist_v;
      qq = (rr * m + (dd >> 1)) / dd;
      v = (d < 0) ? base - longint'(qq) : base + longint'(qq);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
    endfunction

    function void note(kind_e k, logic signed [31:0] x, logic signed [31:0] y);
      goal_t g;
      bit [65:0] d2, la2, mr2;
      bit [32:0] dist_v;
      longint gx, gy;
      int unsigned sel;
      case (k)
        KIND_START: begin
          pt_x[0] = x; pt_y[0] = y; n_pts = 1; scan_idx = 0;
        end
        KIND_APPEND: begin
          if (n_pts < Depth) begin
            pt_x[n_pts] = x; pt_y[n_pts] = y; n_pts++;
          end
        end
        KIND_QUERY: begin
          g = '{default: '0};
          if (n_pts == 0) begin
            g.empty = 1'b1;
          end else begin
            la2 = 66'(la_dist) * 66'(la_dist);
            mr2 = 66'(reach) * 66'(reach);
            sel = n_pts - 1;
            for (int unsigned i = scan_idx; i < n_pts; i++) begin
              if (sq_dist(longint'(pt_x[i]) - x, longint'(pt_y[i]) - y) >= la2) begin
                sel = i; g.found = 1'b1;
                break;
              end
            end
            scan_idx = sel;
            gx = pt_x[sel];
            gy = pt_y[sel];
            d2 = sq_dist(gx - x, gy - y);
            if (d2 > mr2) begin
              dist_v = root(d2);
              if (dist_v == 0) dist_v = 1;
              gx = pull_in(x, gx - x, dist_v);
              gy = pull_in(y, gy - y, dist_v);
              g.clamped = 1'b1;
            end
            g.gx = gx[31:0];
            g.gy = gy[31:0];
            g.idx = sel[9:0];
          end
          goals.push_back(g);
        end
        default: ;
      endcase
    endfunction

    function void check(goal_t got);
      goal_t e;
      if (goals.size() == 0) begin
        report("result with no query pending");
        return;
      end
      e = goals.pop_front();
      if (got.gx !== e.gx) report($sformatf("goal_x %0d exp %0d", got.gx, e.gx));
      if (got.gy !== e.gy) report($sformatf("goal_y %0d exp %0d", got.gy, e.gy));
      if (got.idx !== e.idx) report($sformatf("goal_index %0d exp %0d", got.idx, e.idx));
      if (got.found !== e.found) report($sformatf("beyond_found %b exp %b", got.found, e.found));
      if (got.clamped !== e.clamped)
        report($sformatf("was_clamped %b exp %b", got.clamped, e.clamped));
      if (got.empty !== e.empty) report($sformatf("path_empty %b exp %b", got.empty, e.empty));
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic cfg_index_i;
  logic [RegW-1:0] cfg_wdata_i;

  plps_in_if  in_ch ();
  plps_out_if out_ch ();

  path_lookahead_point_search_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  goal_scoreboard sb = new();
  bit calm;          // no idling on either side
  int hold_req;      // receiver hold-off request, in cycles
  int hold_left;
  int n_items;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: check accepted transactions, then decide next ready
  always @(posedge clk_i or negedge rst_ni) begin
    goal_t g;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        g.gx = out_ch.goal_x;
        g.gy = out_ch.goal_y;
        g.idx = out_ch.goal_index;
        g.found = out_ch.beyond_found;
        g.clamped = out_ch.was_clamped;
        g.empty = out_ch.path_empty;
        sb.check(g);
      end
      if (hold_left == 0 && hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
      end
    end
  end

  task automatic send(kind_e k, logic signed [31:0] x, logic signed [31:0] y);
    if (!calm && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= k;
    in_ch.pos_x <= x;
    in_ch.pos_y <= y;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note(k, x, y);
    n_items++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.goals.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_regs(bit [RegW-1:0] la, bit [RegW-1:0] mr);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_LOOKAHEAD;
    cfg_wdata_i <= la;
    @(posedge clk_i);
    cfg_index_i <= CFG_REACH;
    cfg_wdata_i <= mr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.la_dist = la;
    sb.reach = mr;
  endtask

  function automatic logic signed [31:0] near(logic signed [31:0] c, int span);
    longint v;
    v = longint'(c) + $signed($urandom_range(2 * span)) - span;
    return v[31:0];
  endfunction

  // one well-formed path with random content, then a few queries near it (random in wide mode)
  task automatic path_and_queries();
    logic signed [31:0] cx, cy;
    bit wide;
    wide = ($urandom_range(9) == 0);
    cx = wide ? $urandom : near(0, 1 << 22);
    cy = wide ? $urandom : near(0, 1 << 22);
    send(KIND_START, cx, cy);
    repeat ($urandom_range(9)) begin
      cx = wide ? $urandom : near(cx, 2 << 16);
      cy = wide ? $urandom : near(cy, 2 << 16);
      send(KIND_APPEND, cx, cy);
    end
    repeat ($urandom_range(4, 1)) begin
      if ($urandom_range(19) == 0) send(KIND_NONE, $urandom, $urandom);
      send(KIND_QUERY, wide ? $urandom : near(cx, 12 << 16), wide ? $urandom : near(cy, 12 << 16));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    calm = 1'b0;
    hold_req = 0;
    n_items = 0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_LOOKAHEAD;
    cfg_wdata_i <= '0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_NONE;
    in_ch.pos_x <= '0;
    in_ch.pos_y <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty path, extremes, unused kind, zero lookahead and reach
    send(KIND_QUERY, 32'sd0, 32'sd0);
    send(KIND_NONE, 32'sh7fffffff, 32'sh80000000);
    send(KIND_START, 32'sh80000000, 32'sh80000000);
    send(KIND_APPEND, 32'sh7fffffff, 32'sh7fffffff);
    send(KIND_QUERY, 32'sh7fffffff, 32'sh80000000);
    send(KIND_QUERY, 32'sh80000000, 32'sh7fffffff);
    send(KIND_QUERY, 32'sd0, 32'sd0);
    set_regs('0, '0);
    send(KIND_START, 32'sd65536, -32'sd65536);
    send(KIND_APPEND, 32'sd131072, 32'sd0);
    send(KIND_QUERY, 32'sd0, 32'sd0);
    send(KIND_QUERY, 32'sd65536, -32'sd65536);
    set_regs({RegW{1'b1}}, {RegW{1'b1}});
    send(KIND_QUERY, 32'sh80000000, 32'sh80000000);
    send(KIND_QUERY, 32'sd0, 32'sd0);
    set_regs(31'd65536, 31'd131072);
    send(KIND_START, 32'sd0, 32'sd0);
    for (int i = 1; i < 5; i++) send(KIND_APPEND, i << 16, 32'sd0);
    send(KIND_QUERY, 32'sd0, 32'sd0);
    send(KIND_QUERY, -32'sd655360, 32'sd0);

    // store full: extra appends are dropped, fallback to the last point
    set_regs(31'h7fff0000, 31'd655360);
    calm = 1'b1;
    send(KIND_START, 32'sd0, 32'sd0);
    for (int i = 1; i < Depth + 6; i++) send(KIND_APPEND, i << 8, -(i << 8));
    send(KIND_QUERY, 32'sd0, 32'sd0);
    calm = 1'b0;

    // random phase, several register settings along the way
    n_items = 0;
    while (n_items < 450) begin
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: set_regs(RegW'($urandom_range(4 << 16)), RegW'($urandom_range(16 << 16)));
          1: set_regs(LookaheadRst, ReachRst);
          2: set_regs(RegW'($urandom_range(1 << 16)), RegW'($urandom));
          default: set_regs(RegW'($urandom), RegW'($urandom_range(4 << 16)));
        endcase
      end
      if (n_items > 150 && n_items < 200) calm = 1'b1;
      else calm = 1'b0;
      if (n_items >= 250 && hold_req == 0 && hold_left == 0 && n_items < 262) begin
        // long receiver hold-off while points and queries keep coming
        hold_req = 400;
        send(KIND_START, 32'sd0, 32'sd0);
        send(KIND_QUERY, $urandom, $urandom);
        repeat (30) send(KIND_APPEND, $urandom_range(1 << 20), $urandom_range(1 << 20));
        send(KIND_QUERY, 32'sd0, 32'sd0);
      end
      path_and_queries();
    end

    in_ch.valid <= 1'b0;
    while (sb.goals.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
